### rtl/esc_pkg.sv
// Shared types and constants of the environmental sensor compensation block.
// Used by the top level and by the pipelined divider; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_TEMP_CALIB     = 3'd0,
      REG_PRESS_CALIB_A  = 3'd1,
      REG_PRESS_CALIB_B  = 3'd2,
      REG_PRESS_CALIB_P9 = 3'd3,
      REG_HUMID_CALIB    = 3'd4,
      REG_HUMID_H6       = 3'd5
   } reg_index_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;

   // Quotient bits resolved by the divider, one per stage
   localparam int unsigned DIV_STEPS = 64;

   // Formula constants
   localparam logic [33:0] PRESS_T_OFFSET = 34'd128000;
   localparam logic [31:0] HUM_T_OFFSET   = 32'd76800;
   localparam logic [20:0] PRESS_BASE     = 21'd1048576;
   localparam logic [31:0] PRESS_SCALE    = 32'd3125;
   localparam logic [31:0] HUM_ROUND      = 32'd16384;
   localparam logic [31:0] HUM_INNER_OFS  = 32'd2097152;
   localparam logic [31:0] HUM_MAX        = 32'd419430400;

   // Results that ride alongside the division
   typedef struct packed {
      logic [31:0] temp_c;
      logic [16:0] humid;
      logic        qneg;
      logic        dz;
   } side_type;

   typedef struct packed {
      logic [63:0] an;
      logic [30:0] ad;
      side_type    side;
   } div_req_type;

   typedef struct packed {
      logic [63:0] quot;
      side_type    side;
   } div_rsp_type;

endpackage

`default_nettype wire

### rtl/esc_divider.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on esc_pkg for the request, response and sideband types.
`timescale 1ns / 1ps
`default_nettype none

module esc_divider (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  adv,
   input  wire                  in_valid,
   input  esc_pkg::div_req_type in_data,
   output logic                 out_valid,
   output esc_pkg::div_rsp_type out_data
);
   import esc_pkg::*;

   typedef struct packed {
      logic [30:0] rem;
      logic [63:0] nq;
      logic [30:0] ad;
      side_type    side;
   } stage_type;

   logic      vld_ff [0:DIV_STEPS];
   stage_type st_ff  [0:DIV_STEPS];

   // Load the entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0].rem  <= '0;
         st_ff[0].nq   <= in_data.an;
         st_ff[0].ad   <= in_data.ad;
         st_ff[0].side <= in_data.side;
      end
   end

   // One trial subtraction per stage; numerator bits shift out, quotient bits in
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [31:0] trial;
      stage_type   step_in;

      always_comb begin
         trial   = {st_ff[k].rem, st_ff[k].nq[63]} - {1'b0, st_ff[k].ad};
         step_in = st_ff[k];
         if (!trial[31]) begin
            step_in.rem = trial[30:0];
            step_in.nq  = {st_ff[k].nq[62:0], 1'b1};
         end else begin
            step_in.rem = {st_ff[k].rem[29:0], st_ff[k].nq[63]};
            step_in.nq  = {st_ff[k].nq[62:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[k+1] <= step_in;
         end
      end
   end

   assign out_valid     = vld_ff[DIV_STEPS];
   assign out_data.quot = st_ff[DIV_STEPS].nq;
   assign out_data.side = st_ff[DIV_STEPS].side;

endmodule

`default_nettype wire

### rtl/env_sensor_compensation.sv
// Path: a request accepted on req_ready passes 11 formula stages, the divider entry and 64 quotient
// stages, and 6 pressure stages, then the output register shows its result on rsp_valid.
// Throughput: one request per cycle while the output is not stalled; the 64-stage quotient pipeline sets the depth.
// A stalled output holds the pipeline; a bubble in the last stage still lets requests in.
// Reset (synchronous) clears all valid bits and all calibration registers to zero.
`timescale 1ns / 1ps
`default_nettype none

// Top level: calibration registers, formula pipeline and output register.
// Depends on esc_pkg and esc_divider.
module env_sensor_compensation (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [19:0]                         req_raw_temp,
   input  wire  [19:0]                         req_raw_press,
   input  wire  [15:0]                         req_raw_humid,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic signed [31:0]                  rsp_temp_centi,
   output logic [31:0]                         rsp_press_q24_8,
   output logic [16:0]                         rsp_humid_q22_10,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [esc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [esc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import esc_pkg::*;

   // Stage payloads
   typedef struct packed {
      logic [31:0] at2; logic [31:0] dd; logic [19:0] adc_p; logic [15:0] adc_h;
   } st1_type;
   typedef struct packed {
      logic [31:0] v1t; logic [31:0] dt3; logic [19:0] adc_p; logic [15:0] adc_h;
   } st2_type;
   typedef struct packed {
      logic [31:0] tf; logic [19:0] adc_p; logic [15:0] adc_h;
   } st3_type;
   typedef struct packed {
      logic [31:0] temp_c; logic [33:0] v1; logic [31:0] th;
      logic [19:0] adc_p; logic [15:0] adc_h;
   } st4_type;
   typedef struct packed {
      logic [31:0] temp_c; logic [63:0] vv; logic [63:0] v1p5; logic [63:0] v1p2;
      logic [31:0] h5t; logic [31:0] th6; logic [31:0] th3;
      logic [19:0] adc_p; logic [15:0] adc_h;
   } st5_type;
   typedef struct packed {
      logic [31:0] temp_c; logic [63:0] vv6_lo; logic [31:0] vv6_hi;
      logic [63:0] vv3_lo; logic [31:0] vv3_hi; logic [63:0] v2_part; logic [63:0] v1c;
      logic [31:0] left; logic [31:0] ha; logic [31:0] hb; logic [19:0] adc_p;
   } st6_type;
   typedef struct packed {
      logic [31:0] temp_c; logic [63:0] v2; logic [63:0] v1s;
      logic [31:0] left; logic [31:0] inner_p; logic [19:0] adc_p;
   } st7_type;
   typedef struct packed {
      logic [31:0] temp_c; logic [63:0] n0; logic [47:0] wlo_p1; logic [31:0] whi_p1;
      logic [31:0] left; logic [31:0] r;
   } st8_type;
   typedef struct packed {
      logic [31:0] temp_c; logic [30:0] dv; logic [43:0] nlo; logic [31:0] nhi;
      logic [31:0] left; logic [31:0] right;
   } st9_type;
   typedef struct packed {
      logic [31:0] temp_c; logic [30:0] dv; logic [63:0] n; logic [31:0] x1;
   } st10_type;
   typedef struct packed {
      logic [31:0] temp_c; logic [63:0] an; logic [30:0] ad; logic qneg; logic dz;
      logic [31:0] x1; logic [31:0] x2sq;
   } st11_type;
   typedef struct packed {
      side_type side; logic [63:0] p;
   } q1_type;
   typedef struct packed {
      side_type side; logic [63:0] p; logic [63:0] ll; logic [31:0] hl;
      logic [63:0] p8lo; logic [31:0] p8hi;
   } q2_type;
   typedef struct packed {
      side_type side; logic [63:0] p; logic [63:0] sq; logic [63:0] v2;
   } q3_type;
   typedef struct packed {
      side_type side; logic [63:0] p; logic [63:0] v2; logic [63:0] p9lo; logic [31:0] p9hi;
   } q4_type;
   typedef struct packed {
      side_type side; logic [63:0] sum;
   } q5_type;
   typedef struct packed {
      logic [31:0] temp_c; logic [16:0] humid; logic dz; logic [31:0] press;
   } q6_type;

   // Calibration registers
   logic [47:0] temp_calib_ff;
   logic [63:0] press_calib_a_ff;
   logic [63:0] press_calib_b_ff;
   logic [15:0] press_calib_p9_ff;
   logic [63:0] humid_calib_ff;
   logic [7:0]  humid_h6_ff;

   logic [15:0]        t1, p1;
   logic signed [15:0] t2s, t3s, p2s, p3s, p4s, p5s, p6s, p7s, p8s, p9s;
   logic [7:0]         h1, h3;
   logic signed [15:0] h2s, h4s, h5s;
   logic signed [7:0]  h6s;

   logic pipe_adv;
   logic out_load;
   logic [1:11] vld_ff;
   logic [1:6]  qv_ff;

   st1_type  s1_in,  s1_ff;
   st2_type  s2_in,  s2_ff;
   st3_type  s3_in,  s3_ff;
   st4_type  s4_in,  s4_ff;
   st5_type  s5_in,  s5_ff;
   st6_type  s6_in,  s6_ff;
   st7_type  s7_in,  s7_ff;
   st8_type  s8_in,  s8_ff;
   st9_type  s9_in,  s9_ff;
   st10_type s10_in, s10_ff;
   st11_type s11_in, s11_ff;
   q1_type   q1_in,  q1_ff;
   q2_type   q2_in,  q2_ff;
   q3_type   q3_in,  q3_ff;
   q4_type   q4_in,  q4_ff;
   q5_type   q5_in,  q5_ff;
   q6_type   q6_in,  q6_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        div_out_valid;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_temp_ff;
   logic [31:0]        rsp_press_ff;
   logic [16:0]        rsp_humid_ff;

   // Write calibration registers; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff     <= '0;
         press_calib_a_ff  <= '0;
         press_calib_b_ff  <= '0;
         press_calib_p9_ff <= '0;
         humid_calib_ff    <= '0;
         humid_h6_ff       <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_TEMP_CALIB:     temp_calib_ff     <= csr_wdata[47:0];
            REG_PRESS_CALIB_A:  press_calib_a_ff  <= csr_wdata;
            REG_PRESS_CALIB_B:  press_calib_b_ff  <= csr_wdata;
            REG_PRESS_CALIB_P9: press_calib_p9_ff <= csr_wdata[15:0];
            REG_HUMID_CALIB:    humid_calib_ff    <= csr_wdata;
            REG_HUMID_H6:       humid_h6_ff       <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Unpack coefficients
   assign t1  = temp_calib_ff[15:0];
   assign t2s = $signed(temp_calib_ff[31:16]);
   assign t3s = $signed(temp_calib_ff[47:32]);
   assign p1  = press_calib_a_ff[15:0];
   assign p2s = $signed(press_calib_a_ff[31:16]);
   assign p3s = $signed(press_calib_a_ff[47:32]);
   assign p4s = $signed(press_calib_a_ff[63:48]);
   assign p5s = $signed(press_calib_b_ff[15:0]);
   assign p6s = $signed(press_calib_b_ff[31:16]);
   assign p7s = $signed(press_calib_b_ff[47:32]);
   assign p8s = $signed(press_calib_b_ff[63:48]);
   assign p9s = $signed(press_calib_p9_ff);
   assign h1  = humid_calib_ff[7:0];
   assign h2s = $signed(humid_calib_ff[23:8]);
   assign h3  = humid_calib_ff[31:24];
   assign h4s = $signed(humid_calib_ff[47:32]);
   assign h5s = $signed(humid_calib_ff[63:48]);
   assign h6s = $signed(humid_h6_ff);

   // Advance when the last stage is empty or the output register frees up
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign pipe_adv  = !qv_ff[6] || out_load;
   assign req_ready = pipe_adv;

   // Stage 1: temperature differences and their products
   always_comb begin
      logic [31:0] a32;
      logic [31:0] d32;
      a32         = 32'(req_raw_temp >> 3) - 32'({t1, 1'b0});
      d32         = 32'(req_raw_temp >> 4) - 32'(t1);
      s1_in.at2   = a32 * 32'(t2s);
      s1_in.dd    = d32 * d32;
      s1_in.adc_p = req_raw_press;
      s1_in.adc_h = req_raw_humid;
   end

   // Stage 2: first temperature term, second term times T3
   always_comb begin
      s2_in.v1t   = 32'($signed(s1_ff.at2) >>> 11);
      s2_in.dt3   = 32'($signed(s1_ff.dd) >>> 12) * 32'(t3s);
      s2_in.adc_p = s1_ff.adc_p;
      s2_in.adc_h = s1_ff.adc_h;
   end

   // Stage 3: fine temperature
   always_comb begin
      s3_in.tf    = s2_ff.v1t + 32'($signed(s2_ff.dt3) >>> 14);
      s3_in.adc_p = s2_ff.adc_p;
      s3_in.adc_h = s2_ff.adc_h;
   end

   // Stage 4: output temperature and offsets for pressure and humidity
   always_comb begin
      s4_in.temp_c = 32'($signed((s3_ff.tf << 2) + s3_ff.tf + 32'd128) >>> 8);
      s4_in.v1     = 34'($signed(s3_ff.tf)) - PRESS_T_OFFSET;
      s4_in.th     = s3_ff.tf - HUM_T_OFFSET;
      s4_in.adc_p  = s3_ff.adc_p;
      s4_in.adc_h  = s3_ff.adc_h;
   end

   // Stage 5: square of the pressure offset, P5 and P2 terms, humidity products
   always_comb begin
      logic signed [67:0] vv_full;
      logic signed [49:0] v1p5_full;
      logic signed [49:0] v1p2_full;
      vv_full      = $signed(s4_ff.v1) * $signed(s4_ff.v1);
      v1p5_full    = $signed(s4_ff.v1) * p5s;
      v1p2_full    = $signed(s4_ff.v1) * p2s;
      s5_in.temp_c = s4_ff.temp_c;
      s5_in.vv     = vv_full[63:0];
      s5_in.v1p5   = 64'(v1p5_full);
      s5_in.v1p2   = 64'(v1p2_full);
      s5_in.h5t    = 32'(h5s) * s4_ff.th;
      s5_in.th6    = s4_ff.th * 32'(h6s);
      s5_in.th3    = s4_ff.th * 32'(h3);
      s5_in.adc_p  = s4_ff.adc_p;
      s5_in.adc_h  = s4_ff.adc_h;
   end

   // Stage 6: partial products with P6 and P3, humidity left term
   always_comb begin
      logic signed [48:0] lo6;
      logic signed [48:0] lo3;
      logic [31:0]        hh;
      lo6           = $signed({1'b0, s5_ff.vv[31:0]}) * p6s;
      lo3           = $signed({1'b0, s5_ff.vv[31:0]}) * p3s;
      hh            = 32'(s5_ff.adc_h) << 14;
      s6_in.temp_c  = s5_ff.temp_c;
      s6_in.vv6_lo  = 64'(lo6);
      s6_in.vv6_hi  = s5_ff.vv[63:32] * 32'(p6s);
      s6_in.vv3_lo  = 64'(lo3);
      s6_in.vv3_hi  = s5_ff.vv[63:32] * 32'(p3s);
      s6_in.v2_part = (s5_ff.v1p5 << 17) + (64'(p4s) << 35);
      s6_in.v1c     = s5_ff.v1p2 << 12;
      s6_in.left    = 32'($signed(hh - (32'(h4s) << 20) - s5_ff.h5t + HUM_ROUND) >>> 15);
      s6_in.ha      = 32'($signed(s5_ff.th6) >>> 10);
      s6_in.hb      = 32'($signed(s5_ff.th3) >>> 11) + 32'd32768;
      s6_in.adc_p   = s5_ff.adc_p;
   end

   // Stage 7: combine pressure sums, humidity inner product
   always_comb begin
      logic [63:0] v1a;
      v1a           = s6_ff.vv3_lo + {s6_ff.vv3_hi, 32'b0};
      s7_in.temp_c  = s6_ff.temp_c;
      s7_in.v2      = s6_ff.vv6_lo + {s6_ff.vv6_hi, 32'b0} + s6_ff.v2_part;
      s7_in.v1s     = 64'($signed(v1a) >>> 8) + s6_ff.v1c;
      s7_in.left    = s6_ff.left;
      s7_in.inner_p = s6_ff.ha * s6_ff.hb;
      s7_in.adc_p   = s6_ff.adc_p;
   end

   // Stage 8: divisor partials with P1, numerator before scaling, H2 product
   always_comb begin
      logic [63:0] w;
      logic [20:0] pn;
      w            = 64'h0000_8000_0000_0000 + s7_ff.v1s;
      pn           = PRESS_BASE - {1'b0, s7_ff.adc_p};
      s8_in.temp_c = s7_ff.temp_c;
      s8_in.n0     = (64'(pn) << 31) - s7_ff.v2;
      s8_in.wlo_p1 = 48'(w[31:0]) * 48'(p1);
      s8_in.whi_p1 = w[63:32] * 32'(p1);
      s8_in.left   = s7_ff.left;
      s8_in.r      = (32'($signed(s7_ff.inner_p) >>> 10) + HUM_INNER_OFS) * 32'(h2s);
   end

   // Stage 9: divisor, numerator partials, humidity right term
   always_comb begin
      logic [63:0] wsum;
      wsum         = 64'(s8_ff.wlo_p1) + {s8_ff.whi_p1, 32'b0};
      s9_in.temp_c = s8_ff.temp_c;
      s9_in.dv     = wsum[63:33];
      s9_in.nlo    = 44'(s8_ff.n0[31:0]) * 44'(PRESS_SCALE);
      s9_in.nhi    = s8_ff.n0[63:32] * PRESS_SCALE;
      s9_in.left   = s8_ff.left;
      s9_in.right  = 32'($signed(s8_ff.r + 32'd8192) >>> 14);
   end

   // Stage 10: numerator, humidity product
   always_comb begin
      s10_in.temp_c = s9_ff.temp_c;
      s10_in.dv     = s9_ff.dv;
      s10_in.n      = 64'(s9_ff.nlo) + {s9_ff.nhi, 32'b0};
      s10_in.x1     = s9_ff.left * s9_ff.right;
   end

   // Stage 11: magnitudes and signs for the divider, humidity square
   always_comb begin
      logic [31:0] x2;
      x2             = 32'($signed(s10_ff.x1) >>> 15);
      s11_in.temp_c  = s10_ff.temp_c;
      s11_in.an      = s10_ff.n[63] ? (64'd0 - s10_ff.n) : s10_ff.n;
      s11_in.ad      = s10_ff.dv[30] ? (31'd0 - s10_ff.dv) : s10_ff.dv;
      s11_in.qneg    = s10_ff.n[63] ^ s10_ff.dv[30];
      s11_in.dz      = (s10_ff.dv == 31'd0);
      s11_in.x1      = s10_ff.x1;
      s11_in.x2sq    = x2 * x2;
   end

   // Finish humidity with clamp while handing the pressure to the divider
   always_comb begin
      logic [31:0] hq;
      logic [31:0] x1f;
      logic [16:0] humid;
      hq  = 32'($signed(s11_ff.x2sq) >>> 7) * 32'(h1);
      x1f = s11_ff.x1 - 32'($signed(hq) >>> 4);
      priority if (x1f[31]) begin
         humid = '0;
      end else if (x1f > HUM_MAX) begin
         humid = HUM_MAX[28:12];
      end else begin
         humid = x1f[28:12];
      end
      div_req.an          = s11_ff.an;
      div_req.ad          = s11_ff.ad;
      div_req.side.temp_c = s11_ff.temp_c;
      div_req.side.humid  = humid;
      div_req.side.qneg   = s11_ff.qneg;
      div_req.side.dz     = s11_ff.dz;
   end

   esc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (pipe_adv),
      .in_valid  (vld_ff[11]),
      .in_data   (div_req),
      .out_valid (div_out_valid),
      .out_data  (div_rsp)
   );

   // Post 1: apply quotient sign
   always_comb begin
      q1_in.side = div_rsp.side;
      q1_in.p    = div_rsp.side.qneg ? (64'd0 - div_rsp.quot) : div_rsp.quot;
   end

   // Post 2: square of the scaled pressure in halves, P8 partials
   always_comb begin
      logic [50:0]        ps;
      logic signed [48:0] lo8;
      ps         = q1_ff.p[63:13];
      lo8        = $signed({1'b0, q1_ff.p[31:0]}) * p8s;
      q2_in.side = q1_ff.side;
      q2_in.p    = q1_ff.p;
      q2_in.ll   = 64'(ps[31:0]) * 64'(ps[31:0]);
      q2_in.hl   = 32'($signed(ps[50:32])) * ps[31:0];
      q2_in.p8lo = 64'(lo8);
      q2_in.p8hi = q1_ff.p[63:32] * 32'(p8s);
   end

   // Post 3: assemble the square and the P8 term
   always_comb begin
      logic [63:0] p8p;
      p8p        = q2_ff.p8lo + {q2_ff.p8hi, 32'b0};
      q3_in.side = q2_ff.side;
      q3_in.p    = q2_ff.p;
      q3_in.sq   = q2_ff.ll + {q2_ff.hl[30:0], 33'b0};
      q3_in.v2   = 64'($signed(p8p) >>> 19);
   end

   // Post 4: P9 partials
   always_comb begin
      logic signed [48:0] lo9;
      lo9        = $signed({1'b0, q3_ff.sq[31:0]}) * p9s;
      q4_in.side = q3_ff.side;
      q4_in.p    = q3_ff.p;
      q4_in.v2   = q3_ff.v2;
      q4_in.p9lo = 64'(lo9);
      q4_in.p9hi = q3_ff.sq[63:32] * 32'(p9s);
   end

   // Post 5: sum the three pressure terms
   always_comb begin
      logic [63:0] p9p;
      p9p         = q4_ff.p9lo + {q4_ff.p9hi, 32'b0};
      q5_in.side  = q4_ff.side;
      q5_in.sum   = q4_ff.p + 64'($signed(p9p) >>> 25) + q4_ff.v2;
   end

   // Post 6: final scaling and P7 offset; zero divisor forces zero pressure
   always_comb begin
      q6_in.temp_c = q5_ff.side.temp_c;
      q6_in.humid  = q5_ff.side.humid;
      q6_in.dz     = q5_ff.side.dz;
      q6_in.press  = q5_ff.side.dz ? 32'd0 : (q5_ff.sum[39:8] + (32'(p7s) << 4));
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         qv_ff  <= '0;
      end else if (pipe_adv) begin
         vld_ff <= {req_valid, vld_ff[1:10]};
         qv_ff  <= {div_out_valid, qv_ff[1:5]};
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         s7_ff  <= s7_in;
         s8_ff  <= s8_in;
         s9_ff  <= s9_in;
         s10_ff <= s10_in;
         s11_ff <= s11_in;
         q1_ff  <= q1_in;
         q2_ff  <= q2_in;
         q3_ff  <= q3_in;
         q4_ff  <= q4_in;
         q5_ff  <= q5_in;
         q6_ff  <= q6_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= qv_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_temp_ff  <= $signed(q6_ff.temp_c);
         rsp_press_ff <= q6_ff.press;
         rsp_humid_ff <= q6_ff.humid;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_temp_centi   = rsp_temp_ff;
   assign rsp_press_q24_8  = rsp_press_ff;
   assign rsp_humid_q22_10 = rsp_humid_ff;

`ifndef SYNTHESIS
   // A stalled last stage keeps its result
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (qv_ff[6] && !pipe_adv) |=> qv_ff[6])
      else $error("last stage lost a result during stall");

   // Humidity never leaves its clamp range
   a_humid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_humid_ff <= 17'd102400))
      else $error("humidity outside clamp range");

   // Zero divisor gives zero pressure
   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      (qv_ff[6] && q6_ff.dz) |-> (q6_ff.press == 32'd0))
      else $error("zero divisor did not give zero pressure");

   // Reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("output valid after reset");

   // A taken result with nothing behind it leaves the output empty
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && !qv_ff[6]) |=> !rsp_valid_ff)
      else $error("result repeated");
`endif

endmodule

`default_nettype wire

### test/tb_env_sensor_compensation.sv
// Self-checking testbench for env_sensor_compensation: directed table, then random samples.
// Depends on esc_pkg and the block's RTL; predicts each result with an in-file model.
`timescale 1ns / 1ps

module tb_env_sensor_compensation;
   import esc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] press;
      logic [16:0] humid;
   } reading_type;

   typedef struct {
      logic [19:0] rt;
      logic [19:0] rp;
      logic [15:0] rh;
      bit          known;
      reading_type want;
   } sample_row_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [19:0] req_raw_temp, req_raw_press;
   logic [15:0] req_raw_humid;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_temp_centi;
   logic [31:0] rsp_press_q24_8;
   logic [16:0] rsp_humid_q22_10;
   logic csr_valid, csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // calibration copy
   logic [47:0] cal_t;
   logic [63:0] cal_pa, cal_pb, cal_h;
   logic [15:0] cal_p9;
   logic [7:0]  cal_h6;

   reading_type expected_readings[$];
   int errors = 0;
   int idle_cycles = 0;
   bit rsp_stall_on = 1;

   env_sensor_compensation dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] sra32(logic [31:0] v, int s);
      return $signed(v) >>> s;
   endfunction

   function automatic logic [63:0] sra64(logic [63:0] v, int s);
      return $signed(v) >>> s;
   endfunction

   function automatic logic [63:0] sx16(logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   // predict one compensated reading from raw samples and current calibration
   function automatic reading_type compensate(logic [19:0] rt, logic [19:0] rp,
                                              logic [15:0] rh);
      reading_type r;
      logic [31:0] t1, t2, t3, a, d, v1t, v2t, tf, t;
      logic [31:0] h1, h2, h3, h4, h5, h6, lft, inner, rgt, x1, x2;
      logic [63:0] v1, v2, p, ps, an, ad, q;
      t1 = {16'd0, cal_t[15:0]};
      t2 = {{16{cal_t[31]}}, cal_t[31:16]};
      t3 = {{16{cal_t[47]}}, cal_t[47:32]};
      a = {15'd0, rt[19:3]} - (t1 << 1);
      v1t = sra32(a * t2, 11);
      d = {16'd0, rt[19:4]} - t1;
      v2t = sra32(sra32(d * d, 12) * t3, 14);
      tf = v1t + v2t;
      r.temp = sra32(tf * 32'd5 + 32'd128, 8);
      // pressure, 64-bit wrap
      v1 = {{32{tf[31]}}, tf} - 64'd128000;
      v2 = v1 * v1 * sx16(cal_pb[31:16]);
      v2 += (v1 * sx16(cal_pb[15:0])) << 17;
      v2 += sx16(cal_pa[63:48]) << 35;
      v1 = sra64(v1 * v1 * sx16(cal_pa[47:32]), 8) + ((v1 * sx16(cal_pa[31:16])) << 12);
      v1 = sra64(((64'd1 << 47) + v1) * {48'd0, cal_pa[15:0]}, 33);
      r.press = 0;
      if (v1 != 0) begin
         p = 64'd1048576 - {44'd0, rp};
         p = ((p << 31) - v2) * 64'd3125;
         an = p[63] ? -p : p;
         ad = v1[63] ? -v1 : v1;
         q = an / ad;
         p = (p[63] != v1[63]) ? -q : q;
         ps = sra64(p, 13);
         v1 = sra64(sx16(cal_p9) * ps * ps, 25);
         v2 = sra64(sx16(cal_pb[63:48]) * p, 19);
         p = sra64(p + v1 + v2, 8) + (sx16(cal_pb[47:32]) << 4);
         r.press = p[31:0];
      end
      // humidity, 32-bit wrap
      h1 = {24'd0, cal_h[7:0]};
      h2 = {{16{cal_h[23]}}, cal_h[23:8]};
      h3 = {24'd0, cal_h[31:24]};
      h4 = {{16{cal_h[47]}}, cal_h[47:32]};
      h5 = {{16{cal_h[63]}}, cal_h[63:48]};
      h6 = {{24{cal_h6[7]}}, cal_h6};
      t = tf - 32'd76800;
      lft = sra32(({16'd0, rh} << 14) - (h4 << 20) - h5 * t + 32'd16384, 15);
      inner = sra32(sra32(t * h6, 10) * (sra32(t * h3, 11) + 32'd32768), 10);
      rgt = sra32((inner + 32'd2097152) * h2 + 32'd8192, 14);
      x1 = lft * rgt;
      x2 = sra32(x1, 15);
      x1 -= sra32(sra32(x2 * x2, 7) * h1, 4);
      if (x1[31]) x1 = 0;
      else if (x1 > HUM_MAX) x1 = HUM_MAX;
      r.humid = x1[28:12];
      return r;
   endfunction

   task automatic pause_random();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      repeat (n) @(posedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, logic [63:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         REG_TEMP_CALIB:     cal_t  = val[47:0];
         REG_PRESS_CALIB_A:  cal_pa = val;
         REG_PRESS_CALIB_B:  cal_pb = val;
         REG_PRESS_CALIB_P9: cal_p9 = val[15:0];
         REG_HUMID_CALIB:    cal_h  = val;
         REG_HUMID_H6:       cal_h6 = val[7:0];
         default: ;
      endcase
   endtask

   // hold valid until accepted; keep valid high across back-to-back requests
   task automatic send_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh,
                              bit known, reading_type want, bit gaps);
      reading_type pred;
      if (gaps && $urandom_range(0, 1)) begin
         req_valid <= 0;
         @(posedge clock);
         pause_random();
      end
      req_valid <= 1;
      req_raw_temp <= rt;
      req_raw_press <= rp;
      req_raw_humid <= rh;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = compensate(rt, rp, rh);
      if (known && pred != want)
         $error("table row disagrees with predictor: want %h pred %h", want, pred);
      expected_readings.push_back(known ? want : pred);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_calibration(logic [47:0] t, logic [63:0] pa, logic [63:0] pb,
                                   logic [15:0] p9, logic [63:0] h, logic [7:0] h6);
      write_csr(REG_TEMP_CALIB, {16'd0, t});
      write_csr(REG_PRESS_CALIB_A, pa);
      write_csr(REG_PRESS_CALIB_B, pb);
      write_csr(REG_PRESS_CALIB_P9, {48'd0, p9});
      write_csr(REG_HUMID_CALIB, h);
      write_csr(REG_HUMID_H6, {56'd0, h6});
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // typical factory coefficients, slightly jittered
   task automatic load_typical();
      logic [15:0] t1, p1;
      t1 = 16'd27504 + 16'($urandom_range(0, 2000));
      p1 = 16'd36477 + 16'($urandom_range(0, 2000));
      load_calibration({16'hFC18, 16'd26435, t1},
                       {16'd2855, 16'hD7B4 + 16'($urandom_range(0, 99)), 16'd3024, p1},
                       {16'hE20C, 16'd15500, 16'hFFF9, 16'h008C},
                       16'd6000, {16'd50, 16'd325, 8'd0, 16'd361, 8'd75},
                       8'd30);
   endtask

   sample_row_type rows[$];

   initial begin
      sample_row_type row;
      int phase;
      reset = 1;
      req_valid = 0; req_raw_temp = 0; req_raw_press = 0; req_raw_humid = 0;
      csr_valid = 0; csr_index = 0; csr_wdata = 0;
      cal_t = 0; cal_pa = 0; cal_pb = 0; cal_p9 = 0; cal_h = 0; cal_h6 = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // after reset: every coefficient zero, so pressure divisor is zero
      row = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1, '{32'd0, 32'd0, 17'd0}};
      rows.push_back(row);
      row = '{20'd0, 20'd0, 16'd0, 1, '{32'd0, 32'd0, 17'd0}};
      rows.push_back(row);
      row = '{20'd519888, 20'd415148, 16'd30000, 0, '0};
      rows.push_back(row);
      foreach (rows[i]) send_sample(rows[i].rt, rows[i].rp, rows[i].rh,
                                    rows[i].known, rows[i].want, 0);
      drain();

      // typical coefficients, field extremes
      load_typical();
      rows.delete();
      row = '{20'd519888, 20'd415148, 16'd30000, 0, '0}; rows.push_back(row);
      row = '{20'd0, 20'd0, 16'd0, 0, '0};              rows.push_back(row);
      row = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0, '0};   rows.push_back(row);
      row = '{20'd0, 20'hFFFFF, 16'hFFFF, 0, '0};       rows.push_back(row);
      row = '{20'hFFFFF, 20'd0, 16'd0, 0, '0};          rows.push_back(row);
      row = '{20'd500000, 20'd300000, 16'd65535, 0, '0}; rows.push_back(row);
      row = '{20'd500000, 20'd300000, 16'd1, 0, '0};    rows.push_back(row);
      foreach (rows[i]) send_sample(rows[i].rt, rows[i].rp, rows[i].rh, 0, '0, 1);
      drain();

      // extreme coefficients: all ones, then most negative signed fields
      load_calibration(48'hFFFFFFFFFFFF, '1, '1, 16'hFFFF, '1, 8'hFF);
      send_sample(20'hFFFFF, 20'd0, 16'hFFFF, 0, '0, 1);
      send_sample(20'd12345, 20'hFFFFF, 16'd0, 0, '0, 1);
      drain();
      load_calibration({16'h8000, 16'h8000, 16'hFFFF}, {48'h800080008000, 16'hFFFF},
                       64'h8000800080008000, 16'h8000, 64'h8000800080FFFF01, 8'h80);
      send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0, '0, 1);
      send_sample(20'd0, 20'd0, 16'd0, 0, '0, 1);
      drain();

      // random phases: mostly realistic coefficients, some fully random
      for (phase = 0; phase < 8; phase++) begin
         if (phase % 3 == 2)
            load_calibration(48'(rand64()), rand64(), rand64(), 16'($urandom()), rand64(),
                             8'($urandom()));
         else
            load_typical();
         repeat (125) begin
            if ($urandom_range(0, 3) != 0)
               send_sample(20'($urandom_range(400000, 600000)),
                           20'($urandom_range(200000, 500000)),
                           16'($urandom_range(10000, 50000)), 0, '0, 1);
            else
               send_sample(20'($urandom()), 20'($urandom()), 16'($urandom()), 0, '0, 1);
         end
         if (phase == 3) rsp_stall_on = 0;
         if (phase == 5) rsp_stall_on = 1;
         drain();
      end

      if (errors == 0 && expected_readings.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // result side: random backpressure while rsp_stall_on is set, else always ready
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 0;
      else if (!rsp_stall_on)
         rsp_ready <= 1;
      else
         rsp_ready <= ($urandom_range(0, 19) == 0) ? 0 : ($urandom_range(0, 3) != 0);
   end

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      reading_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            exp_r = expected_readings.pop_front();
            if (rsp_temp_centi !== exp_r.temp) begin
               $error("temp_centi expected %h actual %h", exp_r.temp, rsp_temp_centi);
               errors++;
            end
            if (rsp_press_q24_8 !== exp_r.press) begin
               $error("press_q24_8 expected %h actual %h", exp_r.press, rsp_press_q24_8);
               errors++;
            end
            if (rsp_humid_q22_10 !== exp_r.humid) begin
               $error("humid_q22_10 expected %h actual %h", exp_r.humid, rsp_humid_q22_10);
               errors++;
            end
         end
      end
   end

   // watchdog: stop if nothing is accepted for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
